// ----- rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg: printf conversion spec parser package
// Types, character codes, result codes and lookup functions shared by the
// parser and its checker.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int unsigned NumBitsDefault = 16;
  localparam int unsigned FieldW         = 16;

  // parser phase
  typedef enum logic [2:0] {
    PhIdle,
    PhFlags,
    PhWidth,
    PhPrec,
    PhSpec
  } phase_e;

  // flag bit positions in the flag register
  localparam int unsigned FlagLeft  = 0;
  localparam int unsigned FlagPlus  = 1;
  localparam int unsigned FlagSpace = 2;
  localparam int unsigned FlagAlt   = 3;
  localparam int unsigned FlagZero  = 4;
  localparam int unsigned NumFlags  = 5;

  // characters
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;

  // length codes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenH    = 3'd1;
  localparam logic [2:0] LenL    = 3'd2;
  localparam logic [2:0] LenJ    = 3'd3;
  localparam logic [2:0] LenZ    = 3'd4;
  localparam logic [2:0] LenT    = 3'd5;
  localparam logic [2:0] LenBigL = 3'd6;

  // specifier codes
  localparam logic [3:0] SpecD       = 4'd0;
  localparam logic [3:0] SpecI       = 4'd1;
  localparam logic [3:0] SpecS       = 4'd2;
  localparam logic [3:0] SpecC       = 4'd3;
  localparam logic [3:0] SpecPct     = 4'd4;
  localparam logic [3:0] SpecP       = 4'd5;
  localparam logic [3:0] SpecU       = 4'd6;
  localparam logic [3:0] SpecO       = 4'd7;
  localparam logic [3:0] SpecX       = 4'd8;
  localparam logic [3:0] SpecBigX    = 4'd9;
  localparam logic [3:0] SpecF       = 4'd10;
  localparam logic [3:0] SpecBigF    = 4'd11;
  localparam logic [3:0] SpecUnknown = 4'd12;

  typedef struct packed {
    logic [7:0] ch;
    logic       starts_spec;
  } in_req_t;

  typedef struct packed {
    logic              left_align;
    logic              force_sign;
    logic              space_sign;
    logic              alt_form;
    logic              zero_pad;
    logic [FieldW-1:0] field_width;
    logic [FieldW-1:0] prec_value;
    logic [2:0]        length_code;
    logic [3:0]        specifier_code;
    logic              spec_valid;
  } out_res_t;

  // length modifier letter -> code, LenNone if not a length letter
  function automatic logic [2:0] len_lookup(logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'h68:   code = LenH;     // h
      8'h6C:   code = LenL;     // l
      8'h6A:   code = LenJ;     // j
      8'h7A:   code = LenZ;     // z
      8'h74:   code = LenT;     // t
      8'h4C:   code = LenBigL;  // L
      default: code = LenNone;
    endcase
    return code;
  endfunction

  // conversion character -> code, SpecUnknown if not recognized
  function automatic logic [3:0] spec_lookup(logic [7:0] ch);
    logic [3:0] code;
    case (ch)
      8'h64:   code = SpecD;     // d
      8'h69:   code = SpecI;     // i
      8'h73:   code = SpecS;     // s
      8'h63:   code = SpecC;     // c
      8'h25:   code = SpecPct;   // %
      8'h70:   code = SpecP;     // p
      8'h75:   code = SpecU;     // u
      8'h6F:   code = SpecO;     // o
      8'h78:   code = SpecX;     // x
      8'h58:   code = SpecBigX;  // X
      8'h66:   code = SpecF;     // f
      8'h46:   code = SpecBigF;  // F
      default: code = SpecUnknown;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/printf_spec_parser_top.sv -----
// ----------------------------------------------------------------------------
// printf_spec_parser_top: printf conversion spec parser
// Parses the characters after a '%' one per request and emits one result
// per completed conversion spec.
// ----------------------------------------------------------------------------
// Usage: feed the characters that follow a '%' one per request, with
// starts_spec set on the first one; starts_spec always drops a parse in
// progress. Order is strict: flags (- + space # 0), width digits, optional
// '.' plus precision digits, at most one length letter (h l j z t L), then
// the conversion character, which closes the spec and produces one result.
// Any character not taken by an earlier stage is the conversion character;
// an unrecognized one gives specifier_code 12 with spec_valid low.
// Characters arriving while idle without starts_spec are dropped. Width and
// precision saturate at 2**NUM_BITS-1; the result shows their low 16 bits.
// Rate: one character per clock cycle while in_stall_o is low. Each character
// is decoded and folded into the parse state combinationally (phase decode
// plus one times-ten add and saturate compare per accumulator), and the
// result is registered into the output register, or into the skid stage
// while the output holds a stalled result. A one-entry skid stage behind the
// output register lets input continue while a result waits; in_stall_o rises
// only when both hold a result that the consumer has stalled.
// ----------------------------------------------------------------------------
module printf_spec_parser_top #(
  parameter int unsigned NUM_BITS = psp_pkg::NumBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psp_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psp_pkg::out_res_t out_res_o
);

  localparam int unsigned ExtW = NUM_BITS + 4;   // room for acc*10+9
  localparam logic [NUM_BITS-1:0] AccMax = {NUM_BITS{1'b1}};

  // parse state
  psp_pkg::phase_e                 phase_q, phase_d;
  logic [psp_pkg::NumFlags-1:0]    flags_q, flags_d;
  logic [NUM_BITS-1:0]             width_q, width_d;
  logic [NUM_BITS-1:0]             prec_q, prec_d;
  logic [2:0]                      len_q, len_d;

  // output register and skid stage
  logic              out_valid_q, out_valid_d;
  psp_pkg::out_res_t out_res_q, out_res_d;
  logic              skid_valid_q, skid_valid_d;
  psp_pkg::out_res_t skid_q, skid_d;

  logic              in_fire, out_fire;
  logic              emit;
  psp_pkg::out_res_t res;

  // working copies after a restart
  psp_pkg::phase_e              ph;
  logic [psp_pkg::NumFlags-1:0] fl;
  logic [NUM_BITS-1:0]          wacc, pacc;
  logic [2:0]                   lsel;

  logic [7:0]          ch;
  logic                is_digit, is_dot;
  logic [2:0]          len_code;
  logic                in_width, in_len, in_spec;
  logic [ExtW-1:0]     ext_digit;
  logic [ExtW-1:0]     w_sum, p_sum;
  logic [NUM_BITS-1:0] w_next, p_next;
  logic [NUM_BITS+psp_pkg::FieldW-1:0] w_ext, p_ext;

  assign in_fire  = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  assign ch       = in_req_i.ch;
  assign is_digit = (ch >= psp_pkg::ChZero) && (ch <= psp_pkg::ChNine);
  assign is_dot   = (ch == psp_pkg::ChDot);
  assign len_code = psp_pkg::len_lookup(ch);

  // restart clears everything and enters the flag stage
  always_comb begin
    if (in_req_i.starts_spec) begin
      ph   = psp_pkg::PhFlags;
      fl   = '0;
      wacc = '0;
      pacc = '0;
      lsel = psp_pkg::LenNone;
    end else begin
      ph   = phase_q;
      fl   = flags_q;
      wacc = width_q;
      pacc = prec_q;
      lsel = len_q;
    end
  end

  // acc*10 + digit as shifts and adds, then saturate
  assign ext_digit = {{NUM_BITS{1'b0}}, ch[3:0]};
  assign w_sum = ({4'b0, wacc} << 3) + ({4'b0, wacc} << 1) + ext_digit;
  assign p_sum = ({4'b0, pacc} << 3) + ({4'b0, pacc} << 1) + ext_digit;
  assign w_next = (w_sum > {4'b0, AccMax}) ? AccMax : w_sum[NUM_BITS-1:0];
  assign p_next = (p_sum > {4'b0, AccMax}) ? AccMax : p_sum[NUM_BITS-1:0];

  // next state; a character falls through stages until one takes it
  always_comb begin
    phase_d = ph;
    flags_d = fl;
    width_d = wacc;
    prec_d  = pacc;
    len_d   = lsel;
    emit    = 1'b0;

    in_width = 1'b0;
    in_len   = 1'b0;
    in_spec  = 1'b0;

    case (ph)
      psp_pkg::PhIdle: begin
        // dropped until a restart
      end
      psp_pkg::PhFlags: begin
        if (ch == psp_pkg::ChMinus) begin
          flags_d[psp_pkg::FlagLeft] = 1'b1;
        end else if (ch == psp_pkg::ChPlus) begin
          flags_d[psp_pkg::FlagPlus] = 1'b1;
        end else if (ch == psp_pkg::ChSpace) begin
          flags_d[psp_pkg::FlagSpace] = 1'b1;
        end else if (ch == psp_pkg::ChHash) begin
          flags_d[psp_pkg::FlagAlt] = 1'b1;
        end else if (ch == psp_pkg::ChZero) begin
          flags_d[psp_pkg::FlagZero] = 1'b1;
        end else begin
          in_width = 1'b1;
        end
      end
      psp_pkg::PhWidth: begin
        in_width = 1'b1;
      end
      psp_pkg::PhPrec: begin
        if (is_digit) begin
          prec_d = p_next;
        end else begin
          in_len = 1'b1;
        end
      end
      psp_pkg::PhSpec: begin
        in_spec = 1'b1;
      end
      default: begin
        phase_d = psp_pkg::PhIdle;
      end
    endcase

    if (in_width) begin
      if (is_digit) begin
        phase_d = psp_pkg::PhWidth;
        width_d = w_next;
      end else if (is_dot) begin
        phase_d = psp_pkg::PhPrec;
      end else begin
        in_len = 1'b1;
      end
    end

    if (in_len) begin
      if (len_code != psp_pkg::LenNone) begin
        phase_d = psp_pkg::PhSpec;
        len_d   = len_code;
      end else begin
        in_spec = 1'b1;
      end
    end

    if (in_spec) begin
      emit    = 1'b1;
      phase_d = psp_pkg::PhIdle;
      flags_d = '0;
      width_d = '0;
      prec_d  = '0;
      len_d   = psp_pkg::LenNone;
    end
  end

  // result as it stands when the conversion character arrives
  assign w_ext = {{psp_pkg::FieldW{1'b0}}, wacc};
  assign p_ext = {{psp_pkg::FieldW{1'b0}}, pacc};

  always_comb begin
    res.left_align     = fl[psp_pkg::FlagLeft];
    res.force_sign     = fl[psp_pkg::FlagPlus];
    res.space_sign     = fl[psp_pkg::FlagSpace];
    res.alt_form       = fl[psp_pkg::FlagAlt];
    res.zero_pad       = fl[psp_pkg::FlagZero];
    res.field_width    = w_ext[psp_pkg::FieldW-1:0];
    res.prec_value     = p_ext[psp_pkg::FieldW-1:0];
    res.length_code    = lsel;
    res.specifier_code = psp_pkg::spec_lookup(ch);
    res.spec_valid     = (res.specifier_code != psp_pkg::SpecUnknown);
  end

  // output register with skid: skid fills only if the output is stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_res_d    = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire && emit) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end else begin
        out_valid_d = 1'b1;
        out_res_d   = res;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= psp_pkg::PhIdle;
      flags_q      <= '0;
      width_q      <= '0;
      prec_q       <= '0;
      len_q        <= psp_pkg::LenNone;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        flags_q <= flags_d;
        width_q <= width_d;
        prec_q  <= prec_d;
        len_q   <= len_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    skid_q    <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- rtl/psp_checker.sv -----
// ----------------------------------------------------------------------------
// psp_checker: port-level checks for the spec parser
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module psp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input psp_pkg::out_res_t out_res_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // a new result only follows an accepted request
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without accepted request");

  // input backpressure only after the output was stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // spec_valid agrees with the specifier code
  a_spec_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_res_o.spec_valid == (out_res_o.specifier_code != psp_pkg::SpecUnknown)) &&
      (out_res_o.specifier_code <= psp_pkg::SpecUnknown))
    else $error("specifier code and spec_valid disagree");

  // length code within range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.length_code <= psp_pkg::LenBigL)
    else $error("length code out of range");

endmodule

bind printf_spec_parser_top psp_checker u_psp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

// ----- verif/printf_spec_parser_tb.sv -----
// ----------------------------------------------------------------------------
// printf_spec_parser testbench
// Feeds conversion-spec characters through the request channel, predicts
// every result with a cycle-free model of the parse and checks each result
// field by field. A short directed table comes first, then random specs,
// broken specs and noise under three idling profiles and long output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import psp_pkg::*;

  localparam int unsigned NumBits   = NumBitsDefault;
  localparam int unsigned ItemsPerPh = 500;    // three idling phases
  localparam int unsigned HoldCycles = 60;     // long output hold-off
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 200000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_res_t out_res_o;

  printf_spec_parser_top #(
    .NUM_BITS(NumBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Spec parse predictor: mirrors the strict flags/width/prec/length/conv
  // order. Accumulators are 32 bits wide so any NUM_BITS up to 32 fits.
  // --------------------------------------------------------------------------
  string FlagChars   = "-+ #0";
  string LenLetters  = "hljztL";
  string SpecLetters = "disc%puoxXfF";

  phase_e              parse_ph;
  logic [NumFlags-1:0] parse_flags;
  logic [31:0]         width_acc;
  logic [31:0]         prec_acc;
  logic [2:0]          len_code;

  function automatic void clear_parse();
    parse_ph    = PhIdle;
    parse_flags = '0;
    width_acc   = '0;
    prec_acc    = '0;
    len_code    = LenNone;
  endfunction

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= ChZero && ch <= ChNine;
  endfunction

  // acc*10 + digit, clamped to the all-ones value of NUM_BITS
  function automatic logic [31:0] add_digit(logic [31:0] acc, logic [7:0] ch);
    logic [63:0] sum;
    logic [63:0] top;
    top = (64'd1 << NumBits) - 64'd1;
    sum = 64'(acc) * 64'd10 + 64'(ch - ChZero);
    return (sum > top) ? top[31:0] : sum[31:0];
  endfunction

  // Folds one accepted request into the parse; returns 1 with the result
  // when the conversion character closes the spec.
  function automatic bit parse_char(in_req_t r, output out_res_t res);
    logic [3:0] conv;
    bit         to_len;
    res    = '0;
    conv   = SpecUnknown;
    to_len = 1'b0;
    if (r.starts_spec) begin
      clear_parse();
      parse_ph = PhFlags;
    end
    if (parse_ph == PhIdle) return 1'b0;

    if (parse_ph == PhFlags) begin
      case (r.ch)
        ChMinus: begin parse_flags[FlagLeft]  = 1'b1; return 1'b0; end
        ChPlus:  begin parse_flags[FlagPlus]  = 1'b1; return 1'b0; end
        ChSpace: begin parse_flags[FlagSpace] = 1'b1; return 1'b0; end
        ChHash:  begin parse_flags[FlagAlt]   = 1'b1; return 1'b0; end
        ChZero:  begin parse_flags[FlagZero]  = 1'b1; return 1'b0; end
        default: parse_ph = PhWidth;
      endcase
    end
    if (parse_ph == PhWidth) begin
      if (is_digit(r.ch)) begin
        width_acc = add_digit(width_acc, r.ch);
        return 1'b0;
      end
      if (r.ch == ChDot) begin
        parse_ph = PhPrec;
        return 1'b0;
      end
      to_len = 1'b1;
    end else if (parse_ph == PhPrec) begin
      if (is_digit(r.ch)) begin
        prec_acc = add_digit(prec_acc, r.ch);
        return 1'b0;
      end
      to_len = 1'b1;
    end
    if (to_len) begin
      parse_ph = PhSpec;
      for (int k = 0; k < 6; k++) begin
        if (r.ch == LenLetters[k]) begin
          len_code = 3'(k + 1);
          return 1'b0;
        end
      end
    end

    // conversion character
    for (int k = 0; k < 12; k++) begin
      if (r.ch == SpecLetters[k] && conv == SpecUnknown) conv = 4'(k);
    end
    res.left_align     = parse_flags[FlagLeft];
    res.force_sign     = parse_flags[FlagPlus];
    res.space_sign     = parse_flags[FlagSpace];
    res.alt_form       = parse_flags[FlagAlt];
    res.zero_pad       = parse_flags[FlagZero];
    res.field_width    = width_acc[FieldW-1:0];
    res.prec_value     = prec_acc[FieldW-1:0];
    res.length_code    = len_code;
    res.specifier_code = conv;
    res.spec_valid     = (conv != SpecUnknown);
    clear_parse();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  out_res_t    spec_results_q[$];   // results still owed by the parser
  int unsigned errors;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(out_res_t got);
    out_res_t want;
    if (spec_results_q.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, got %h", $time, got);
      errors++;
      return;
    end
    want = spec_results_q.pop_front();
    check_field("left_align", want.left_align, got.left_align);
    check_field("force_sign", want.force_sign, got.force_sign);
    check_field("space_sign", want.space_sign, got.space_sign);
    check_field("alt_form", want.alt_form, got.alt_form);
    check_field("zero_pad", want.zero_pad, got.zero_pad);
    check_field("field_width", want.field_width, got.field_width);
    check_field("prec_value", want.prec_value, got.prec_value);
    check_field("length_code", want.length_code, got.length_code);
    check_field("specifier_code", want.specifier_code, got.specifier_code);
    check_field("spec_valid", want.spec_valid, got.spec_valid);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: checks at each accepting edge, then picks next cycle's stall.
  // A hold-off request from the stimulus starts a long stall burst, counted
  // here so that the sender keeps pushing and the skid stage fills.
  // --------------------------------------------------------------------------
  int unsigned recv_idle_pct;
  int unsigned send_idle_pct;
  bit          hold_req;
  int unsigned hold_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_res_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // hard stop if the handshake hangs
  int unsigned cycles;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, spec_results_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int unsigned chars_sent;   // requests the parser does not just drop

  // One request; the predictor runs at the accepting edge. Expectations typed
  // into the directed table replace the predicted one.
  task automatic send_char(logic [7:0] ch, bit start, bit typed = 1'b0,
                           bit typed_has = 1'b0, out_res_t typed_res = '0);
    in_req_t  r;
    out_res_t res;
    bit       has;
    r.ch          = ch;
    r.starts_spec = start;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (start || parse_ph != PhIdle) chars_sent++;
    has = parse_char(r, res);
    if (typed) begin
      if (typed_has) spec_results_q.push_back(typed_res);
    end else if (has) begin
      spec_results_q.push_back(res);
    end
  endtask

  // Random spec in the legal order. cut > 0 truncates it so the next spec
  // restarts mid-parse; a small share ends in an arbitrary byte.
  task automatic send_random_spec(bit cut);
    logic [7:0] seq[$];
    int unsigned n;
    n = ($urandom_range(9) == 0) ? $urandom_range(5) : $urandom_range(2);
    repeat (n) seq.push_back(FlagChars[$urandom_range(4)]);
    // mostly short numbers, now and then enough digits to saturate
    n = ($urandom_range(19) == 0) ? $urandom_range(8, 5) : $urandom_range(3);
    for (int i = 0; i < n; i++)
      seq.push_back((i == 0) ? 8'($urandom_range(ChNine, ChZero + 1))
                             : 8'($urandom_range(ChNine, ChZero)));
    if ($urandom_range(1)) begin
      seq.push_back(ChDot);
      n = ($urandom_range(19) == 0) ? $urandom_range(8, 5) : $urandom_range(3);
      repeat (n) seq.push_back(8'($urandom_range(ChNine, ChZero)));
    end
    if ($urandom_range(1)) seq.push_back(LenLetters[$urandom_range(5)]);
    if ($urandom_range(99) < 85) seq.push_back(SpecLetters[$urandom_range(11)]);
    else seq.push_back(8'($urandom_range(255)));
    n = cut ? $urandom_range(seq.size() - 1, 1) : seq.size();
    for (int i = 0; i < n; i++) send_char(seq[i], i == 0);
  endtask

  function automatic out_res_t mk_res(logic [4:0] flags, logic [15:0] w, logic [15:0] p,
                                      logic [2:0] len, logic [3:0] conv, logic ok);
    out_res_t r;
    {r.zero_pad, r.alt_form, r.space_sign, r.force_sign, r.left_align} = flags;
    r.field_width    = w;
    r.prec_value     = p;
    r.length_code    = len;
    r.specifier_code = conv;
    r.spec_valid     = ok;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: one row per request
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    bit         start;
    bit         typed;      // expectation given in the row itself
    bit         typed_has;
    out_res_t   res;
  } char_row_t;

  char_row_t directed_rows[$];

  function automatic void add_row(logic [7:0] ch, bit start, bit typed = 1'b0,
                                  bit typed_has = 1'b0, out_res_t res = '0);
    char_row_t row;
    row.ch        = ch;
    row.start     = start;
    row.typed     = typed;
    row.typed_has = typed_has;
    row.res       = res;
    directed_rows.push_back(row);
  endfunction

  initial begin
    clear_parse();
    errors        = 0;
    cycles        = 0;
    chars_sent    = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    send_idle_pct = 30;
    recv_idle_pct = 45;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    out_stall_i   = 1'b0;

    // bare "%d": all fields at their reset values
    add_row("d", 1'b1, 1'b1, 1'b1, mk_res(5'b0, 16'd0, 16'd0, LenNone, SpecD, 1'b1));
    // every flag, a width whose second digit is '0', precision, length L
    add_row(ChMinus, 1'b1);
    add_row(ChPlus, 1'b0);
    add_row(ChSpace, 1'b0);
    add_row(ChHash, 1'b0);
    add_row(ChZero, 1'b0);
    add_row("9", 1'b0);
    add_row(ChZero, 1'b0);     // digit here, not a flag
    add_row(ChDot, 1'b0);
    add_row("5", 1'b0);
    add_row("L", 1'b0);
    add_row("F", 1'b0);
    // stray character while idle is dropped
    add_row("x", 1'b0, 1'b1, 1'b0);
    // restart throws away the width in progress
    add_row("5", 1'b1);
    add_row("x", 1'b1, 1'b1, 1'b1, mk_res(5'b0, 16'd0, 16'd0, LenNone, SpecX, 1'b1));
    // unknown conversion characters at both byte extremes
    add_row(8'h00, 1'b1, 1'b1, 1'b1, mk_res(5'b0, 16'd0, 16'd0, LenNone, SpecUnknown, 1'b0));
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, mk_res(5'b0, 16'd0, 16'd0, LenNone, SpecUnknown, 1'b0));
    // width past the field maximum saturates
    add_row("9", 1'b1);
    repeat (5) add_row("9", 1'b0);
    add_row("u", 1'b0, 1'b1, 1'b1, mk_res(5'b0, 16'hFFFF, 16'd0, LenNone, SpecU, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].start, directed_rows[i].typed,
                directed_rows[i].typed_has, directed_rows[i].res);

    // random traffic under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 30 : 0;
      hold_req = 1'b1;   // long output stall while requests keep coming
      while (chars_sent < (ph + 1) * ItemsPerPh) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_random_spec(1'b0);
        end else if (pick < 90) begin
          send_random_spec(1'b1);
        end else begin
          // noise: arbitrary bytes, start bit random
          repeat ($urandom_range(4, 1))
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
      // sender pause until the parser has delivered everything
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (spec_results_q.size() != 0) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && spec_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
